FILE: design/trc_pkg.sv
// Shared constants, rate ROM and pipeline types for the timestamp rate converter.
// No dependencies; imported by every module of the block.
package trc_pkg;

   // stamp layout
   localparam int STAMP_W  = 64;
   localparam int KEY_W    = 8;
   localparam int CNT_W    = 56;
   localparam int KEY_COUNT = 19;

   // operation codes
   localparam logic [1:0] OP_CONVERT  = 2'd0;
   localparam logic [1:0] OP_COMPARE  = 2'd1;
   localparam logic [1:0] OP_SUBTRACT = 2'd2;

   // order codes (two's complement)
   localparam logic [1:0] ORD_EQUAL   = 2'b00;
   localparam logic [1:0] ORD_LATER   = 2'b01;
   localparam logic [1:0] ORD_EARLIER = 2'b11;

   // datapath widths
   localparam int STEP_W   = 10;              // largest step 1001
   localparam int SCALE_W  = 20;              // largest scale 1000000
   localparam int RATIO_W  = STEP_W + SCALE_W; // numerator / denominator
   localparam int HALF_W   = CNT_W / 2;
   localparam int PP_W     = HALF_W + RATIO_W;
   localparam int PROD_W   = CNT_W + RATIO_W;
   localparam int BITS_PER_STAGE = 2;
   localparam int DIV_STAGES = (PROD_W + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
   localparam int MUL_STAGES = 3;
   localparam int NUM_STAGES = MUL_STAGES + DIV_STAGES;

   // side data that travels with each beat
   typedef struct packed {
      logic             ok;
      logic [1:0]       op;
      logic [KEY_W-1:0] dst;
   } meta_type;

   // tick step per key; out-of-range keys read as 1 so the divisor stays nonzero
   function automatic logic [STEP_W-1:0] rate_step(input logic [KEY_W-1:0] key);
      logic [STEP_W-1:0] s;
      unique case (key)
         8'd0, 8'd12, 8'd13, 8'd14, 8'd15, 8'd16: s = 10'd1;
         8'd4, 8'd7, 8'd10:                       s = 10'd1001;
         8'd1, 8'd2, 8'd3, 8'd5, 8'd6, 8'd8, 8'd9,
         8'd11, 8'd17, 8'd18:                     s = 10'd1000;
         default:                                 s = 10'd1;
      endcase
      return s;
   endfunction

   function automatic logic [SCALE_W-1:0] rate_scale(input logic [KEY_W-1:0] key);
      logic [SCALE_W-1:0] s;
      unique case (key)
         8'd0:  s = 20'd1000;
         8'd1:  s = 20'd10000;
         8'd2:  s = 20'd15000;
         8'd3:  s = 20'd20000;
         8'd4:  s = 20'd24000;
         8'd5:  s = 20'd24000;
         8'd6:  s = 20'd25000;
         8'd7:  s = 20'd30000;
         8'd8:  s = 20'd30000;
         8'd9:  s = 20'd50000;
         8'd10: s = 20'd60000;
         8'd11: s = 20'd60000;
         8'd12: s = 20'd44100;
         8'd13: s = 20'd48000;
         8'd14: s = 20'd90000;
         8'd15: s = 20'd270000;
         8'd16: s = 20'd1000000;
         8'd17: s = 20'd120000;
         8'd18: s = 20'd240000;
         default: s = 20'd1;
      endcase
      return s;
   endfunction

endpackage

FILE: design/timestamp_rate_converter_core.sv
// Top level of the timestamp rate converter: handshake, side data, two lanes, result.
// Depends on trc_pkg, trc_mult and trc_div.
//
// Usage: a request beat carries an op, two stamps and a target key on the req_
// channel; each request yields exactly one response beat on the rsp_ channel,
// in order. Op 0 converts stamp A to the target key, op 1 orders A against B
// in milliseconds, op 2 gives A minus B in milliseconds.
// Pipeline: 3 multiply stages, 43 divider stages at two quotient bits each over
// the 86-bit product, then one result register. Throughput: one beat per cycle
// while the output is not stalled, set by the fully pipelined divider; both
// stamps go through parallel lanes.
// Stall: when rsp_ready is low, the result register holds and stages behind
// it fill up; req_ready stays high as long as any stage holds a bubble.
// Reset clears all stage valid bits and the response valid bit; no request is
// lost or repeated across a stall.
module timestamp_rate_converter_core import trc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_op,
   input  logic [STAMP_W-1:0]   req_stamp_a,
   input  logic [STAMP_W-1:0]   req_stamp_b,
   input  logic [KEY_W-1:0]     req_target_rate,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_valid_res,
   output logic [STAMP_W-1:0]   rsp_stamp_out,
   output logic signed [1:0]    rsp_order,
   output logic signed [STAMP_W-1:0] rsp_difference
);

   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] adv;
   meta_type              meta_ff [NUM_STAGES];
   meta_type              meta_in;
   logic                  out_adv;
   logic                  rsp_valid_ff;
   logic                  res_ok_ff;
   logic [STAMP_W-1:0]    stamp_ff, stamp_in;
   logic [1:0]            order_ff, order_in;
   logic [STAMP_W-1:0]    diff_ff, diff_in;
   logic [KEY_W-1:0]      key_a, key_b, dst_a;
   logic [PROD_W-1:0]     dvd_a, dvd_b;
   logic [RATIO_W-1:0]    den_a, den_b;
   logic [CNT_W-1:0]      quo_a, quo_b;

   // stage advance: a stage loads when empty or when the next one moves
   assign out_adv = !rsp_valid_ff || rsp_ready;
   always_comb begin
      adv[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || out_adv;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end
   assign req_ready = adv[0];

   // key checks and lane routing
   assign key_a = req_stamp_a[STAMP_W-1:CNT_W];
   assign key_b = req_stamp_b[STAMP_W-1:CNT_W];
   assign dst_a = (req_op == OP_CONVERT) ? req_target_rate : '0;
   always_comb begin
      meta_in.op  = req_op;
      meta_in.dst = dst_a;
      unique case (req_op)
         OP_CONVERT:  meta_in.ok = (key_a < KEY_W'(KEY_COUNT)) &&
                                   (req_target_rate < KEY_W'(KEY_COUNT));
         OP_COMPARE,
         OP_SUBTRACT: meta_in.ok = (key_a < KEY_W'(KEY_COUNT)) &&
                                   (key_b < KEY_W'(KEY_COUNT));
         default:     meta_in.ok = 1'b0;
      endcase
   end

   // beat valid bits and side data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         meta_ff[0] <= meta_in;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (adv[k]) begin
            meta_ff[k] <= meta_ff[k-1];
         end
      end
   end

   // lane A: stamp A to target (op 0) or milliseconds
   trc_mult u_mult_a (
      .clock   (clock),
      .adv     (adv[MUL_STAGES-1:0]),
      .count_i (req_stamp_a[CNT_W-1:0]),
      .src_i   (key_a),
      .dst_i   (dst_a),
      .dvd_o   (dvd_a),
      .den_o   (den_a)
   );

   trc_div u_div_a (
      .clock (clock),
      .adv   (adv[NUM_STAGES-1:MUL_STAGES]),
      .dvd_i (dvd_a),
      .den_i (den_a),
      .quo_o (quo_a)
   );

   // lane B: stamp B to milliseconds
   trc_mult u_mult_b (
      .clock   (clock),
      .adv     (adv[MUL_STAGES-1:0]),
      .count_i (req_stamp_b[CNT_W-1:0]),
      .src_i   (key_b),
      .dst_i   ('0),
      .dvd_o   (dvd_b),
      .den_o   (den_b)
   );

   trc_div u_div_b (
      .clock (clock),
      .adv   (adv[NUM_STAGES-1:MUL_STAGES]),
      .dvd_i (dvd_b),
      .den_i (den_b),
      .quo_o (quo_b)
   );

   // result formatting
   always_comb begin
      stamp_in = '0;
      order_in = ORD_EQUAL;
      diff_in  = '0;
      if (meta_ff[NUM_STAGES-1].ok) begin
         unique case (meta_ff[NUM_STAGES-1].op)
            OP_CONVERT:  stamp_in = {meta_ff[NUM_STAGES-1].dst, quo_a};
            OP_COMPARE:  order_in = (quo_a < quo_b) ? ORD_EARLIER :
                                    ((quo_a > quo_b) ? ORD_LATER : ORD_EQUAL);
            OP_SUBTRACT: diff_in  = STAMP_W'(quo_a) - STAMP_W'(quo_b);
            default:     stamp_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_adv) begin
         rsp_valid_ff <= vld_ff[NUM_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv) begin
         res_ok_ff <= meta_ff[NUM_STAGES-1].ok;
         stamp_ff  <= stamp_in;
         order_ff  <= order_in;
         diff_ff   <= diff_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_valid_res  = res_ok_ff;
   assign rsp_stamp_out  = stamp_ff;
   assign rsp_order      = order_ff;
   assign rsp_difference = diff_ff;

endmodule

FILE: design/trc_mult.sv
// Front of one conversion lane: ROM lookup, split count multiply, product sum.
// Depends on trc_pkg.
module trc_mult import trc_pkg::*; (
   input  logic                   clock,
   input  logic [MUL_STAGES-1:0]  adv,
   input  logic [CNT_W-1:0]       count_i,
   input  logic [KEY_W-1:0]       src_i,
   input  logic [KEY_W-1:0]       dst_i,
   output logic [PROD_W-1:0]      dvd_o,
   output logic [RATIO_W-1:0]     den_o
);

   logic [CNT_W-1:0]   cnt_ff,  cnt_in;
   logic [RATIO_W-1:0] num_ff,  num_in;
   logic [RATIO_W-1:0] den0_ff, den0_in;
   logic [PP_W-1:0]    pp_lo_ff, pp_hi_ff;
   logic [RATIO_W-1:0] den1_ff;
   logic [PROD_W-1:0]  dvd_ff, dvd_in;
   logic [RATIO_W-1:0] den2_ff;

   // stage 0: ratio terms; same key gives 1/1 so the count passes unchanged
   always_comb begin
      cnt_in = count_i;
      if (src_i == dst_i) begin
         num_in  = RATIO_W'(1);
         den0_in = RATIO_W'(1);
      end else begin
         num_in  = RATIO_W'(rate_step(src_i)) * RATIO_W'(rate_scale(dst_i));
         den0_in = RATIO_W'(rate_scale(src_i)) * RATIO_W'(rate_step(dst_i));
      end
   end

   // stage 2 sum of partial products
   assign dvd_in = PROD_W'(pp_lo_ff) + (PROD_W'(pp_hi_ff) << HALF_W);

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         cnt_ff  <= cnt_in;
         num_ff  <= num_in;
         den0_ff <= den0_in;
      end
      // stage 1: two half-width products
      if (adv[1]) begin
         pp_lo_ff <= PP_W'(cnt_ff[HALF_W-1:0]) * PP_W'(num_ff);
         pp_hi_ff <= PP_W'(cnt_ff[CNT_W-1:HALF_W]) * PP_W'(num_ff);
         den1_ff  <= den0_ff;
      end
      if (adv[2]) begin
         dvd_ff  <= dvd_in;
         den2_ff <= den1_ff;
      end
   end

   assign dvd_o = dvd_ff;
   assign den_o = den2_ff;

endmodule

FILE: design/trc_div.sv
// Pipelined restoring divider, two quotient bits per stage, low count bits kept.
// Depends on trc_pkg.
module trc_div import trc_pkg::*; (
   input  logic                   clock,
   input  logic [DIV_STAGES-1:0]  adv,
   input  logic [PROD_W-1:0]      dvd_i,
   input  logic [RATIO_W-1:0]     den_i,
   output logic [CNT_W-1:0]       quo_o
);

   logic [RATIO_W-1:0] rem_ff [DIV_STAGES];
   logic [PROD_W-1:0]  dvd_ff [DIV_STAGES];
   logic [CNT_W-1:0]   quo_ff [DIV_STAGES];
   logic [RATIO_W-1:0] den_ff [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic [RATIO_W-1:0] rem_s;
      logic [PROD_W-1:0]  dvd_s;
      logic [CNT_W-1:0]   quo_s;
      logic [RATIO_W-1:0] den_s;
      logic [RATIO_W-1:0] rem_in;
      logic [PROD_W-1:0]  dvd_in;
      logic [CNT_W-1:0]   quo_in;
      logic [RATIO_W-1:0] den_in;

      // stage input: fresh dividend at the head, previous stage elsewhere
      if (k == 0) begin : g_head
         assign rem_s = '0;
         assign dvd_s = dvd_i;
         assign quo_s = '0;
         assign den_s = den_i;
      end else begin : g_body
         assign rem_s = rem_ff[k-1];
         assign dvd_s = dvd_ff[k-1];
         assign quo_s = quo_ff[k-1];
         assign den_s = den_ff[k-1];
      end

      // shift in one dividend bit per step, subtract when it fits
      always_comb begin
         logic [RATIO_W:0] part;
         rem_in = rem_s;
         dvd_in = dvd_s;
         quo_in = quo_s;
         den_in = den_s;
         for (int b = 0; b < BITS_PER_STAGE; b++) begin
            part = {rem_in, dvd_in[PROD_W-1]};
            dvd_in = {dvd_in[PROD_W-2:0], 1'b0};
            if (part >= {1'b0, den_in}) begin
               part = part - {1'b0, den_in};
               quo_in = {quo_in[CNT_W-2:0], 1'b1};
            end else begin
               quo_in = {quo_in[CNT_W-2:0], 1'b0};
            end
            rem_in = part[RATIO_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (adv[k]) begin
            rem_ff[k] <= rem_in;
            dvd_ff[k] <= dvd_in;
            quo_ff[k] <= quo_in;
            den_ff[k] <= den_in;
         end
      end
   end

   assign quo_o = quo_ff[DIV_STAGES-1];

endmodule
